// File: hw/rtl/sprite_sort_and_batch_assert.svh
// assertion macros shared by the sprite sort and batch rtl
`ifndef SPRITE_SORT_AND_BATCH_ASSERT_SVH
`define SPRITE_SORT_AND_BATCH_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SPSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SPSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/spsb_pkg.sv
// shared types and constants for the sprite sort and batch block
`timescale 1ns / 1ps

package spsb_pkg;

  // sort order selected by the mode register
  typedef enum logic [1:0] {
    MODE_DEPTH_ASC  = 2'd0,
    MODE_DEPTH_DESC = 2'd1,
    MODE_TEX_ASC    = 2'd2,
    MODE_NONE       = 2'd3
  } sort_mode_t;

  localparam sort_mode_t MODE_RESET = MODE_TEX_ASC;
  localparam logic [7:0] VERTS_PER_SPRITE = 8'd6;

  // one input item
  typedef struct packed {
    logic [31:0]        texture_id;
    logic signed [31:0] depth;
    logic               is_last;
  } spsb_in_t;

  // one result item
  typedef struct packed {
    logic [4:0]  sprite_index;
    logic [31:0] sprite_texture;
    logic [7:0]  vertex_offset;
    logic        starts_batch;
    logic [7:0]  batch_vertices;
    logic        overflowed;
    logic        last_result;
  } spsb_out_t;

  // frame start request from the load side to the sorter
  typedef struct packed {
    logic       go;
    sort_mode_t mode;
    logic       ovf;
  } spsb_start_t;

endpackage

// File: hw/rtl/spsb_cmp.sv
// shared 32-bit compare unit: unsigned less-than and equality
`timescale 1ns / 1ps

module spsb_cmp
  import spsb_pkg::*;
(
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        lt_o,
  output logic        eq_o
);

  // one compare unit feeds both sort and batch decisions
  assign lt_o = (a_i < b_i);
  assign eq_o = (a_i == b_i);

endmodule

// File: hw/rtl/spsb_sorter.sv
// frame store, insertion sort sequencer, run-length pass and emission
`timescale 1ns / 1ps
`include "sprite_sort_and_batch_assert.svh"

module spsb_sorter
  import spsb_pkg::*;
#(
  parameter int MAX_SPRITES = 32,
  localparam int IW = $clog2(MAX_SPRITES),
  localparam int CW = $clog2(MAX_SPRITES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  spsb_start_t   start_i,
  input  logic [CW-1:0] n_i,
  input  logic          wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  spsb_in_t      wr_data_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output spsb_out_t     res_o
);

  localparam logic [31:0]   SIGN_FLIP = 32'h8000_0000;
  localparam logic [CW-1:0] ONE       = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_SGET,
    S_SCUR,
    S_SCMP,
    S_SPUT,
    S_RUN,
    S_EMIT
  } state_t;

  // sorted entry: arrival slot, sort key, texture
  typedef struct packed {
    logic [IW-1:0] idx;
    logic [31:0]   key;
    logic [31:0]   tex;
  } ent_t;

  // key that turns every mode into an ascending unsigned compare
  function automatic logic [31:0] sort_key(sort_mode_t m, logic [31:0] tex,
                                           logic [31:0] dep);
    case (m)
      MODE_DEPTH_ASC:  return dep ^ SIGN_FLIP;
      MODE_DEPTH_DESC: return ~(dep ^ SIGN_FLIP);
      MODE_TEX_ASC:    return tex;
      default:         return '0;
    endcase
  endfunction

  // memories
  logic [63:0]   st_mem  [MAX_SPRITES];
  ent_t          srt_mem [MAX_SPRITES];
  logic [CW-1:0] run_mem [MAX_SPRITES];

  logic [63:0]   st_rd_r;
  ent_t          srt_rd_r;
  logic [CW-1:0] run_rd_r;

  // sequencer registers
  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] n_r, n_nxt;
  sort_mode_t    mode_r, mode_nxt;
  logic          ovf_r, ovf_nxt;
  ent_t          cur_r, cur_nxt;
  logic [31:0]   nxt_tex_r, nxt_tex_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [31:0]   prev_tex_r, prev_tex_nxt;
  logic [7:0]    voff_r, voff_nxt;

  // memory controls
  logic [IW-1:0] st_raddr;
  logic [IW-1:0] srt_raddr;
  logic          srt_we;
  logic [IW-1:0] srt_waddr;
  ent_t          srt_wdata;
  logic [IW-1:0] run_raddr;
  logic          run_we;
  logic [IW-1:0] run_waddr;
  logic [CW-1:0] run_wdata;

  // shared compare unit
  logic [31:0] cmp_a, cmp_b;
  logic        cmp_lt, cmp_eq;

  logic [CW-1:0] cnt_m1, cnt_p1, j_m1, j_m2, run_v;
  logic [IW+4:0] idx_ext;
  logic [CW+7:0] run_ext;
  logic [7:0]    run8, bverts;
  logic          is_start;

  spsb_cmp u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .lt_o (cmp_lt),
    .eq_o (cmp_eq)
  );

  assign cnt_m1 = cnt_r - ONE;
  assign cnt_p1 = cnt_r + ONE;
  assign j_m1   = j_r - ONE;
  assign j_m2   = j_r - CW'(2);

  // output field shaping for the entry read last cycle
  assign idx_ext = {5'b0, srt_rd_r.idx};
  assign run_ext = {8'b0, run_rd_r};
  assign run8    = run_ext[7:0];
  assign bverts  = {run8[5:0], 2'b00} + {run8[6:0], 1'b0};

  // sprite store, written by the load side
  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      st_mem[wr_addr_i] <= {wr_data_i.texture_id, wr_data_i.depth};
    end
    st_rd_r <= st_mem[st_raddr];
  end

  // sorted order store
  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_waddr] <= srt_wdata;
    end
    srt_rd_r <= srt_mem[srt_raddr];
  end

  // run length per sorted position
  always_ff @(posedge clk) begin
    if (run_we) begin
      run_mem[run_waddr] <= run_wdata;
    end
    run_rd_r <= run_mem[run_raddr];
  end

  // sequencer next state
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    j_nxt        = j_r;
    n_nxt        = n_r;
    mode_nxt     = mode_r;
    ovf_nxt      = ovf_r;
    cur_nxt      = cur_r;
    nxt_tex_nxt  = nxt_tex_r;
    run_nxt      = run_r;
    prev_tex_nxt = prev_tex_r;
    voff_nxt     = voff_r;
    st_raddr     = cnt_r[IW-1:0];
    srt_raddr    = cnt_r[IW-1:0];
    srt_we       = 1'b0;
    srt_waddr    = cnt_m1[IW-1:0];
    srt_wdata    = cur_r;
    run_raddr    = cnt_r[IW-1:0];
    run_we       = 1'b0;
    run_waddr    = cnt_r[IW-1:0];
    run_wdata    = run_r;
    run_v        = ONE;
    cmp_a        = '0;
    cmp_b        = '0;
    is_start     = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;

    case (state_r)
      S_IDLE: begin
        if (start_i.go) begin
          n_nxt     = n_i;
          mode_nxt  = start_i.mode;
          ovf_nxt   = start_i.ovf;
          cnt_nxt   = '0;
          state_nxt = S_INIT;
        end
      end

      // copy the store into the order array with keys, one slot a cycle
      S_INIT: begin
        if (cnt_r != '0) begin
          srt_we        = 1'b1;
          srt_waddr     = cnt_m1[IW-1:0];
          srt_wdata.idx = cnt_m1[IW-1:0];
          srt_wdata.key = sort_key(mode_r, st_rd_r[63:32], st_rd_r[31:0]);
          srt_wdata.tex = st_rd_r[63:32];
        end
        if (cnt_r == n_r) begin
          if (mode_r == MODE_NONE || n_r == ONE) begin
            state_nxt = S_RUN;
          end else begin
            cnt_nxt   = ONE;
            state_nxt = S_SGET;
          end
        end else begin
          cnt_nxt = cnt_p1;
        end
      end

      // fetch the entry to insert
      S_SGET: begin
        state_nxt = S_SCUR;
      end

      S_SCUR: begin
        cur_nxt   = srt_rd_r;
        j_nxt     = cnt_r;
        srt_raddr = cnt_m1[IW-1:0];
        state_nxt = S_SCMP;
      end

      // shift larger entries up until the slot is found
      S_SCMP: begin
        cmp_a     = cur_r.key;
        cmp_b     = srt_rd_r.key;
        srt_we    = 1'b1;
        srt_waddr = j_r[IW-1:0];
        if (cmp_lt) begin
          srt_wdata = srt_rd_r;
          j_nxt     = j_m1;
          if (j_m1 != '0) begin
            srt_raddr = j_m2[IW-1:0];
          end else begin
            state_nxt = S_SPUT;
          end
        end else begin
          srt_wdata = cur_r;
          cnt_nxt   = cnt_p1;
          state_nxt = (cnt_p1 == n_r) ? S_RUN : S_SGET;
        end
      end

      S_SPUT: begin
        srt_we    = 1'b1;
        srt_waddr = '0;
        srt_wdata = cur_r;
        cnt_nxt   = cnt_p1;
        state_nxt = (cnt_p1 == n_r) ? S_RUN : S_SGET;
      end

      // backward pass: length of the texture run from each position
      S_RUN: begin
        srt_raddr = cnt_m1[IW-1:0];
        if (cnt_r != n_r) begin
          cmp_a = srt_rd_r.tex;
          cmp_b = nxt_tex_r;
          if (cnt_r != n_r - ONE && cmp_eq) begin
            run_v = run_r + ONE;
          end
          run_we      = 1'b1;
          run_waddr   = cnt_r[IW-1:0];
          run_wdata   = run_v;
          run_nxt     = run_v;
          nxt_tex_nxt = srt_rd_r.tex;
        end
        if (cnt_r == '0) begin
          voff_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          cnt_nxt = cnt_m1;
        end
      end

      // forward pass: one result per sorted position
      S_EMIT: begin
        if (cnt_r != '0) begin
          cmp_a                = srt_rd_r.tex;
          cmp_b                = prev_tex_r;
          is_start             = (cnt_r == ONE) || !cmp_eq;
          res_valid_o          = 1'b1;
          res_o.sprite_index   = idx_ext[4:0];
          res_o.sprite_texture = srt_rd_r.tex;
          res_o.vertex_offset  = voff_r;
          res_o.starts_batch   = is_start;
          res_o.batch_vertices = is_start ? bverts : 8'd0;
          res_o.overflowed     = ovf_r;
          res_o.last_result    = (cnt_r == n_r);
          prev_tex_nxt         = srt_rd_r.tex;
          voff_nxt             = voff_r + VERTS_PER_SPRITE;
        end
        if (cnt_r == n_r) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_p1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      j_r     <= '0;
      n_r     <= '0;
      mode_r  <= MODE_RESET;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      j_r     <= j_nxt;
      n_r     <= n_nxt;
      mode_r  <= mode_nxt;
      ovf_r   <= ovf_nxt;
    end
    cur_r      <= cur_nxt;
    nxt_tex_r  <= nxt_tex_nxt;
    run_r      <= run_nxt;
    prev_tex_r <= prev_tex_nxt;
    voff_r     <= voff_nxt;
  end

  assign busy_o = (state_r != S_IDLE);

  // insertion point stays inside the sorted prefix
  `SPSB_ASSERT_NOW(a_shift_range, state_r == S_SCMP, (j_r != '0) && (j_r <= cnt_r), "insertion index out of range")

endmodule

// File: hw/rtl/sprite_sort_and_batch.sv
// top level: sprite load, mode register, sorter and result register
//
//  channel   ports                                   handshake
//  input     start, busy, in_data                    taken when start && !busy
//  result    out_valid, out_data                     no stall
//  config    cfg_valid, cfg_ready, cfg_data          taken when valid && ready
//
// A sprite that is not last is taken in the cycle it is presented, so a frame
// loads at one item per cycle while busy is low. The last item starts the
// frame sequence (n sprites): a store-to-order copy, an insertion sort (one
// shared compare and one read port on the order store), a run-length pass,
// then emission with the n results on consecutive cycles through the result
// register. Mode 3 and a single-sprite frame skip the sort.
// busy is high from the cycle after the last item until emission is done.
// Reset clears counters, flags and the mode (ascending texture); the sprite
// store needs no clearing. Results cannot be stalled.
`timescale 1ns / 1ps
`include "sprite_sort_and_batch_assert.svh"

module sprite_sort_and_batch
  import spsb_pkg::*;
#(
  parameter int MAX_SPRITES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  spsb_in_t   in_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  output logic       out_valid,
  output spsb_out_t  out_data
);

  localparam int IW = $clog2(MAX_SPRITES);
  localparam int CW = $clog2(MAX_SPRITES + 1);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(MAX_SPRITES);

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  sort_mode_t    mode_r, mode_nxt;
  logic          out_valid_r;
  spsb_out_t     out_data_r;

  logic          accept, full, wr_en;
  spsb_start_t   start_req;
  logic [CW-1:0] frame_n;
  logic          res_valid;
  spsb_out_t     res;

  assign accept = start && !busy;
  assign full   = (count_r == FULL);
  assign wr_en  = accept && !full;

  // frame fill count, overflow and sorter kick-off
  always_comb begin
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    start_req.go   = 1'b0;
    start_req.mode = mode_r;
    start_req.ovf  = ovf_r | full;
    frame_n        = full ? count_r : count_r + ONE;
    if (accept) begin
      if (in_data.is_last) begin
        start_req.go = 1'b1;
        count_nxt    = '0;
        ovf_nxt      = 1'b0;
      end else if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + ONE;
      end
    end
  end

  // mode register write
  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid && cfg_ready) begin
      mode_nxt = sort_mode_t'(cfg_data);
    end
  end

  assign cfg_ready = 1'b1;

  spsb_sorter #(
    .MAX_SPRITES (MAX_SPRITES)
  ) u_sorter (
    .clk         (clk),
    .rst_n       (rst_n),
    .start_i     (start_req),
    .n_i         (frame_n),
    .wr_en_i     (wr_en),
    .wr_addr_i   (count_r[IW-1:0]),
    .wr_data_i   (in_data),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // control registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      mode_r      <= MODE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= res_valid;
    end
    out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // frame sequence behavior
  `SPSB_ASSERT_NEXT(a_last_busy, accept && in_data.is_last, busy, "last item did not start the frame")
  `SPSB_ASSERT_NEXT(a_burst, out_valid && !out_data.last_result, out_valid, "gap inside a result burst")
  `SPSB_ASSERT_NEXT(a_end, out_valid && out_data.last_result, !out_valid, "result after the final one")

endmodule

// File: bench/tb_sprite_sort_and_batch.sv
// testbench for sprite_sort_and_batch: frame loads, sorted emission and batch checks
`timescale 1ns / 1ps

module tb_sprite_sort_and_batch;
  import spsb_pkg::*;

  localparam int SPRITE_CAP  = 32;
  localparam int CYCLE_LIMIT = 400000;

  // predicts the sorted, batched sprite list of each frame and checks results
  class sprite_order_model;
    spsb_out_t          expected_draws[$];
    logic [31:0]        held_tex[SPRITE_CAP];
    logic signed [31:0] held_dep[SPRITE_CAP];
    int unsigned        held_count;
    bit                 dropped;
    sort_mode_t         mode;
    int unsigned        mismatches;

    function new();
      held_count = 0;
      dropped    = 0;
      mode       = MODE_RESET;
      mismatches = 0;
    endfunction

    function void set_mode(sort_mode_t m);
      mode = m;
    endfunction

    // true if sprite a must strictly precede sprite b
    function bit precedes(int a, int b);
      case (mode)
        MODE_DEPTH_ASC:  return held_dep[a] < held_dep[b];
        MODE_DEPTH_DESC: return held_dep[a] > held_dep[b];
        MODE_TEX_ASC:    return held_tex[a] < held_tex[b];
        default:         return 1'b0;
      endcase
    endfunction

    // note an accepted item; a last item queues the whole frame
    function void take_sprite(spsb_in_t it);
      int        order[SPRITE_CAP];
      int        n, i, j, cur, s, run;
      bit        first;
      spsb_out_t d;
      if (held_count < SPRITE_CAP) begin
        held_tex[held_count] = it.texture_id;
        held_dep[held_count] = it.depth;
        held_count++;
      end else begin
        dropped = 1;
      end
      if (!it.is_last) return;
      n = held_count;
      // stable insertion sort of arrival slots
      for (i = 0; i < n; i++) order[i] = i;
      for (i = 1; i < n; i++) begin
        cur = order[i];
        j = i;
        while (j > 0 && precedes(cur, order[j-1])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = cur;
      end
      // one result per sorted sprite, runs of equal texture form batches
      for (i = 0; i < n; i++) begin
        s = order[i];
        first = (i == 0) || (held_tex[s] != held_tex[order[i-1]]);
        run = 0;
        if (first) begin
          run = 1;
          for (j = i + 1; j < n && held_tex[order[j]] == held_tex[s]; j++) run++;
        end
        d.sprite_index   = s[4:0];
        d.sprite_texture = held_tex[s];
        d.vertex_offset  = 8'(i) * VERTS_PER_SPRITE;
        d.starts_batch   = first;
        d.batch_vertices = 8'(run) * VERTS_PER_SPRITE;
        d.overflowed     = dropped;
        d.last_result    = (i == n - 1);
        expected_draws.push_back(d);
      end
      held_count = 0;
      dropped    = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // compare one emitted result with the oldest expected one
    task match_draw(spsb_out_t got);
      spsb_out_t want;
      if (expected_draws.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", got));
        return;
      end
      want = expected_draws.pop_front();
      if (got.sprite_index !== want.sprite_index)
        report_mismatch($sformatf("sprite_index %0d, want %0d",
                                  got.sprite_index, want.sprite_index));
      if (got.sprite_texture !== want.sprite_texture)
        report_mismatch($sformatf("sprite_texture %h, want %h",
                                  got.sprite_texture, want.sprite_texture));
      if (got.vertex_offset !== want.vertex_offset)
        report_mismatch($sformatf("vertex_offset %0d, want %0d",
                                  got.vertex_offset, want.vertex_offset));
      if (got.starts_batch !== want.starts_batch)
        report_mismatch($sformatf("starts_batch %b, want %b",
                                  got.starts_batch, want.starts_batch));
      if (got.batch_vertices !== want.batch_vertices)
        report_mismatch($sformatf("batch_vertices %0d, want %0d",
                                  got.batch_vertices, want.batch_vertices));
      if (got.overflowed !== want.overflowed)
        report_mismatch($sformatf("overflowed %b, want %b",
                                  got.overflowed, want.overflowed));
      if (got.last_result !== want.last_result)
        report_mismatch($sformatf("last_result %b, want %b",
                                  got.last_result, want.last_result));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  spsb_in_t   in_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;
  logic       out_valid;
  spsb_out_t  out_data;

  sprite_order_model sb = new();
  int unsigned       idle_pct;
  int unsigned       cycle_count;

  // directed sprite table: texture and depth extremes with repeated keys
  logic [31:0] dir_tex [7] = '{32'h0000_0005, 32'h0000_0000, 32'hFFFF_FFFF,
                               32'h0000_0005, 32'h0000_0000, 32'h0000_0005,
                               32'hFFFF_FFFF};
  logic [31:0] dir_dep [7] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                               32'hFFFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                               32'h0000_0000};

  sprite_sort_and_batch i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.match_draw(out_data);
  end

  function automatic logic [31:0] pick_texture();
    case ($urandom_range(0, 9))
      0:          return 32'h0000_0000;
      1:          return 32'hFFFF_FFFF;
      2, 3, 4, 5: return 32'($urandom_range(0, 3));
      default:    return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_depth();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3, 4: return 32'($signed($urandom_range(0, 4)) - 2);
      default: return $urandom;
    endcase
  endfunction

  // present one item and hold it until taken; optionally drop start afterwards
  task automatic send_item(spsb_in_t it, bit hold);
    int gap;
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    sb.take_sprite(it);
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (!hold && gap == 0) gap = 1;
    if (gap > 0) begin
      start   <= 1'b0;
      in_data <= spsb_in_t'({$urandom, $urandom, 1'($urandom)});
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for the frame to drain and the block to go idle
  task automatic wait_frame_drained();
    while (sb.expected_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_mode(sort_mode_t m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    sb.set_mode(m);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_table_frame(int first, int count);
    spsb_in_t it;
    for (int i = 0; i < count; i++) begin
      it.texture_id = dir_tex[first + i];
      it.depth      = dir_dep[first + i];
      it.is_last    = (i == count - 1);
      send_item(it, i < count - 1);
    end
  endtask

  task automatic send_random_frame(int n, bit hold_end);
    spsb_in_t it;
    for (int i = 0; i < n; i++) begin
      it.texture_id = pick_texture();
      it.depth      = pick_depth();
      it.is_last    = (i == n - 1);
      send_item(it, (i < n - 1) || hold_end);
    end
  endtask

  // stimulus
  initial begin
    int       rand_items;
    int       frame_no;
    int       n;
    bit       do_cfg;
    spsb_in_t one;
    cycle_count = 0;
    idle_pct    = 10;
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a lone sprite, then the table under every sort mode
    one.texture_id = 32'hFFFF_FFFF;
    one.depth      = 32'h7FFF_FFFF;
    one.is_last    = 1'b1;
    send_item(one, 1'b0);
    wait_frame_drained();
    send_table_frame(0, 7);
    wait_frame_drained();
    write_mode(MODE_DEPTH_ASC);
    send_table_frame(0, 6);
    wait_frame_drained();
    write_mode(MODE_DEPTH_DESC);
    send_table_frame(1, 6);
    wait_frame_drained();
    write_mode(MODE_NONE);
    send_table_frame(2, 5);
    wait_frame_drained();
    write_mode(MODE_TEX_ASC);

    // random frames: an overflowing one, a full one, then mostly small ones
    rand_items = 0;
    frame_no   = 0;
    while (rand_items < 75) begin
      idle_pct = (rand_items < 25) ? 10 : (rand_items < 50) ? 86 : 0;
      if (frame_no == 0) n = SPRITE_CAP + 2;
      else if (frame_no == 1) n = SPRITE_CAP;
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(9, SPRITE_CAP - 1);
      else n = $urandom_range(1, 8);
      do_cfg = ($urandom_range(0, 2) == 0);
      send_random_frame(n, !do_cfg && (rand_items + n < 75));
      rand_items += n;
      if (do_cfg) begin
        wait_frame_drained();
        write_mode(sort_mode_t'($urandom_range(0, 3)));
      end
      frame_no++;
    end

    // drain and finish
    while (sb.expected_draws.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_draws.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sprite_sort_and_batch.f
+incdir+hw/rtl
hw/rtl/spsb_pkg.sv
hw/rtl/spsb_cmp.sv
hw/rtl/spsb_sorter.sv
hw/rtl/sprite_sort_and_batch.sv
bench/tb_sprite_sort_and_batch.sv
